@@ src/ttam_pkg.sv @@
// Package for the touch tap averaging and mapping block.
// Holds field widths, event codes, register indexes, state types and lane structs.
// No dependencies; imported by every module under src.
package ttam_pkg;

    // Screen size and sample limit
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAX_SAMPLES   = 1024;

    // Field widths
    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VAL_W   = 16;
    localparam int SCR_W   = 12;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Sample counter and running sums
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = VAL_W + CNT_W;

    // Mapping arithmetic: offset into bounds times (size - 1)
    localparam int SPAN_W  = VAL_W + 1;
    localparam int PROD_W  = SPAN_W + SCR_W;

    // Shared divider widths
    localparam int DIV_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DEN_W   = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // Screen extents minus one
    localparam logic [SCR_W-1:0] SCREEN_X_M1 = SCR_W'(SCREEN_WIDTH - 1);
    localparam logic [SCR_W-1:0] SCREEN_Y_M1 = SCR_W'(SCREEN_HEIGHT - 1);

    // Event classes and codes
    localparam logic [TYPE_W-1:0] EVT_SYNC      = TYPE_W'(0);
    localparam logic [TYPE_W-1:0] EVT_KEY       = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] EVT_ABS       = TYPE_W'(3);
    localparam logic [CODE_W-1:0] SYNC_REPORT   = CODE_W'(0);
    localparam logic [CODE_W-1:0] KEY_TOUCH     = CODE_W'(330);
    localparam logic [CODE_W-1:0] AXIS_X        = CODE_W'(0);
    localparam logic [CODE_W-1:0] AXIS_Y        = CODE_W'(1);
    localparam logic [CODE_W-1:0] AXIS_PRESSURE = CODE_W'(24);

    // Calibration register indexes
    localparam logic [CIDX_W-1:0] CFG_X_MIN = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_X_MAX = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_Y_MIN = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] CFG_Y_MAX = CIDX_W'(3);

    // Calibration reset values
    localparam logic signed [CFG_W-1:0] CAL_X_MIN_RST = CFG_W'(221);
    localparam logic signed [CFG_W-1:0] CAL_X_MAX_RST = CFG_W'(3807);
    localparam logic signed [CFG_W-1:0] CAL_Y_MIN_RST = CFG_W'(282);
    localparam logic signed [CFG_W-1:0] CAL_Y_MAX_RST = CFG_W'(3800);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } top_state_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_AVG,
        LN_MUL,
        LN_MST,
        LN_MAP,
        LN_DONE
    } lane_state_t;

    // Top to lane control
    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

    // Lane to top status
    typedef struct packed {
        logic busy;
        logic valid;
    } lane_stat_t;

endpackage

@@ src/ttam_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Unsigned dividend and divisor; quotient holds after the done pulse.
// Depends on ttam_pkg.
module ttam_div
    import ttam_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    sub;
    logic              ge;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        sub   = trial - {1'b0, den_reg};
        ge    = ~sub[DEN_W];
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = DCNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/ttam_lane.sv @@
// One axis lane: averages the running sum, then clamps and maps it to screen units.
// Reuses one bit-serial divider for both divisions.
// Depends on ttam_pkg and ttam_div.
module ttam_lane
    import ttam_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_ctl_t               ctl,
    input  logic signed [SUM_W-1:0] sum,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [CFG_W-1:0] lo,
    input  logic signed [CFG_W-1:0] hi,
    input  logic [SCR_W-1:0]        size_m1,
    output lane_stat_t              stat,
    output logic signed [VAL_W-1:0] raw,
    output logic [SCR_W-1:0]        screen
);

    lane_state_t              state_reg, state_next;
    logic                     sign_reg, sign_next;
    logic signed [VAL_W-1:0]  avg_reg, avg_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [SPAN_W-1:0]        span_reg, span_next;
    logic                     zero_reg, zero_next;
    logic [SCR_W-1:0]         screen_reg, screen_next;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;

    logic [SUM_W-1:0]         abs_sum;
    logic signed [VAL_W-1:0]  clamped;
    logic [SPAN_W-1:0]        offset;
    logic [SPAN_W-1:0]        span;

    ttam_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Magnitude of the sum, clamp and offsets for mapping
    always_comb begin
        abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        if (avg_reg < lo) begin
            clamped = lo;
        end else if (avg_reg > hi) begin
            clamped = hi;
        end else begin
            clamped = avg_reg;
        end
        offset = {clamped[VAL_W-1], clamped} - {lo[CFG_W-1], lo};
        span   = {hi[CFG_W-1], hi} - {lo[CFG_W-1], lo};
    end

    // Sequence: average divide, multiply, map divide, hold result
    always_comb begin
        state_next   = state_reg;
        sign_next    = sign_reg;
        avg_next     = avg_reg;
        prod_next    = prod_reg;
        span_next    = span_reg;
        zero_next    = zero_reg;
        screen_next  = screen_reg;
        div_start    = 1'b0;
        div_dividend = DIV_W'(prod_reg);
        div_divisor  = DEN_W'(span_reg);
        unique case (state_reg)
            LN_IDLE: begin
                div_dividend = DIV_W'(abs_sum);
                div_divisor  = DEN_W'(count);
                if (ctl.start) begin
                    div_start  = 1'b1;
                    sign_next  = sum[SUM_W-1];
                    state_next = LN_AVG;
                end
            end
            LN_AVG: begin
                if (div_done) begin
                    avg_next   = sign_reg ? -div_quo[VAL_W-1:0] : div_quo[VAL_W-1:0];
                    state_next = LN_MUL;
                end
            end
            LN_MUL: begin
                prod_next  = PROD_W'(offset) * PROD_W'(size_m1);
                span_next  = span;
                zero_next  = (hi <= lo);
                state_next = LN_MST;
            end
            LN_MST: begin
                div_start  = 1'b1;
                state_next = LN_MAP;
            end
            LN_MAP: begin
                if (div_done) begin
                    screen_next = zero_reg ? '0 : div_quo[SCR_W-1:0];
                    state_next  = LN_DONE;
                end
            end
            LN_DONE: begin
                if (ctl.ack) begin
                    state_next = LN_IDLE;
                end
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        sign_reg   <= sign_next;
        avg_reg    <= avg_next;
        prod_reg   <= prod_next;
        span_reg   <= span_next;
        zero_reg   <= zero_next;
        screen_reg <= screen_next;
    end

    assign stat.busy  = (state_reg != LN_IDLE) && (state_reg != LN_DONE);
    assign stat.valid = (state_reg == LN_DONE);
    assign raw        = avg_reg;
    assign screen     = screen_reg;

endmodule

@@ src/touch_tap_average_and_map.sv @@
// Top level of the touch tap averaging and mapping block.
// Tracks touch state, accumulates samples and runs one ttam_lane per axis.
// Depends on ttam_pkg, ttam_lane and ttam_div.
//
// Usage:
//   Input channel s_*: one input event per transaction (type, code, value).
//   Result channel m_*: average raw X/Y and calibrated screen X/Y of one tap.
//   Config port cfg_*: write-only calibration bounds, one 16-bit register per
//   write; write only while no tap calculation is running.
// Timing:
//   Sync, axis, press and ignored events are taken back to back.
//   A release with samples starts both axis lanes; each lane runs a bit-serial
//   divider twice plus a multiply step. s_ready stays low until the result
//   is loaded into the output register. Touch state is cleared as the release
//   is accepted.
// Stall and reset:
//   The result sits in an output register; new events are taken while it
//   waits. A following tap result holds in its lanes until m_ready frees it.
//   Reset clears touch state, loads the default calibration and drops m_valid.
module touch_tap_average_and_map
    import ttam_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [TYPE_W-1:0]        s_event_type,
    input  logic [CODE_W-1:0]        s_event_code,
    input  logic signed [VAL_W-1:0]  s_event_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [VAL_W-1:0]  m_raw_x,
    output logic signed [VAL_W-1:0]  m_raw_y,
    output logic [SCR_W-1:0]         m_screen_x,
    output logic [SCR_W-1:0]         m_screen_y,
    input  logic                     cfg_we,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata
);

    top_state_t               state_reg, state_next;
    logic signed [CFG_W-1:0]  cal_x_min_reg, cal_x_max_reg, cal_y_min_reg, cal_y_max_reg;

    logic                     pen_down_reg, pen_down_next;
    logic signed [VAL_W-1:0]  pressure_reg, pressure_next;
    logic signed [VAL_W-1:0]  cur_x_reg, cur_x_next;
    logic signed [VAL_W-1:0]  cur_y_reg, cur_y_next;
    logic                     seen_x_reg, seen_x_next;
    logic                     seen_y_reg, seen_y_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [VAL_W-1:0]  raw_x_reg, raw_y_reg;
    logic [SCR_W-1:0]         scr_x_reg, scr_y_reg;

    logic                     s_fire;
    logic                     release_tap;
    logic                     load_out;
    lane_ctl_t                lane_ctl;
    lane_stat_t               stat_x, stat_y;
    logic signed [VAL_W-1:0]  lane_raw_x, lane_raw_y;
    logic [SCR_W-1:0]         lane_scr_x, lane_scr_y;

    ttam_lane u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sum     (sum_x_reg),
        .count   (count_reg),
        .lo      (cal_x_min_reg),
        .hi      (cal_x_max_reg),
        .size_m1 (SCREEN_X_M1),
        .stat    (stat_x),
        .raw     (lane_raw_x),
        .screen  (lane_scr_x)
    );

    ttam_lane u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sum     (sum_y_reg),
        .count   (count_reg),
        .lo      (cal_y_min_reg),
        .hi      (cal_y_max_reg),
        .size_m1 (SCREEN_Y_M1),
        .stat    (stat_y),
        .raw     (lane_raw_y),
        .screen  (lane_scr_y)
    );

    assign s_fire = s_valid && s_ready;

    // Decode events and update touch state
    always_comb begin
        pen_down_next = pen_down_reg;
        pressure_next = pressure_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        seen_x_next   = seen_x_reg;
        seen_y_next   = seen_y_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        count_next    = count_reg;
        release_tap   = 1'b0;
        if (s_fire) begin
            priority if (s_event_type == EVT_KEY) begin
                if (s_event_code == KEY_TOUCH) begin
                    priority if (s_event_value != '0) begin
                        pen_down_next = 1'b1;
                    end else if (pen_down_reg && (count_reg != '0)) begin
                        release_tap   = 1'b1;
                        pen_down_next = 1'b0;
                        pressure_next = '0;
                        cur_x_next    = '0;
                        cur_y_next    = '0;
                        seen_x_next   = 1'b0;
                        seen_y_next   = 1'b0;
                        sum_x_next    = '0;
                        sum_y_next    = '0;
                        count_next    = '0;
                    end else begin
                        pen_down_next = 1'b0;
                    end
                end
            end else if (s_event_type == EVT_ABS) begin
                priority if (s_event_code == AXIS_PRESSURE) begin
                    pressure_next = s_event_value;
                end else if (s_event_code == AXIS_X) begin
                    cur_x_next  = s_event_value;
                    seen_x_next = 1'b1;
                end else if (s_event_code == AXIS_Y) begin
                    cur_y_next  = s_event_value;
                    seen_y_next = 1'b1;
                end else begin
                    pressure_next = pressure_reg;
                end
            end else if (s_event_type == EVT_SYNC) begin
                if ((s_event_code == SYNC_REPORT) && pen_down_reg && (pressure_reg > 0) &&
                    seen_x_reg && seen_y_reg && (count_reg < CNT_W'(MAX_SAMPLES))) begin
                    sum_x_next = sum_x_reg + SUM_W'(cur_x_reg);
                    sum_y_next = sum_y_reg + SUM_W'(cur_y_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end else begin
                pen_down_next = pen_down_reg;
            end
        end
    end

    // Control: start lanes on a release, hand their result to the output register
    always_comb begin
        state_next   = state_reg;
        lane_ctl     = '0;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (release_tap) begin
                    lane_ctl.start = 1'b1;
                    state_next     = ST_CALC;
                end
            end
            ST_CALC: begin
                if (stat_x.valid && stat_y.valid && (!m_valid_reg || m_ready)) begin
                    load_out     = 1'b1;
                    lane_ctl.ack = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            pen_down_reg <= 1'b0;
            pressure_reg <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            seen_x_reg   <= 1'b0;
            seen_y_reg   <= 1'b0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            pen_down_reg <= pen_down_next;
            pressure_reg <= pressure_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            seen_x_reg   <= seen_x_next;
            seen_y_reg   <= seen_y_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            count_reg    <= count_next;
        end
    end

    // Calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_x_min_reg <= CAL_X_MIN_RST;
            cal_x_max_reg <= CAL_X_MAX_RST;
            cal_y_min_reg <= CAL_Y_MIN_RST;
            cal_y_max_reg <= CAL_Y_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_X_MIN: cal_x_min_reg <= cfg_wdata;
                CFG_X_MAX: cal_x_max_reg <= cfg_wdata;
                CFG_Y_MIN: cal_y_min_reg <= cfg_wdata;
                CFG_Y_MAX: cal_y_max_reg <= cfg_wdata;
                default:   cal_x_min_reg <= cal_x_min_reg;
            endcase
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            raw_x_reg <= lane_raw_x;
            raw_y_reg <= lane_raw_y;
            scr_x_reg <= lane_scr_x;
            scr_y_reg <= lane_scr_y;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_raw_x    = raw_x_reg;
    assign m_raw_y    = raw_y_reg;
    assign m_screen_x = scr_x_reg;
    assign m_screen_y = scr_y_reg;

    // Both lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat_x.valid == stat_y.valid) && (stat_x.busy == stat_y.busy))
        else $error("axis lanes out of step");

    // While calculating, the lanes are working or holding a result
    a_calc_lanes_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (stat_x.busy || stat_x.valid))
        else $error("calculation state with idle lanes");

    // A release clears the touch state in the next cycle
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        release_tap |=> ((count_reg == '0) && !pen_down_reg && (sum_x_reg == '0)))
        else $error("touch state not cleared after release");

    // Sample count saturates at its limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above limit");

    // Screen coordinates stay on screen
    a_screen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (({1'b0, m_screen_x} < (SCR_W + 1)'(SCREEN_WIDTH)) &&
                     ({1'b0, m_screen_y} < (SCR_W + 1)'(SCREEN_HEIGHT))))
        else $error("screen coordinate out of range");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for touch_tap_average_and_map: touch events in, averaged taps out.
// Predicts each tap result from its own copy of the touch state and calibration bounds.
// Depends on ttam_pkg and the RTL under src.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ttam_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 80;

    typedef struct {
        logic [TYPE_W-1:0]       etype;
        logic [CODE_W-1:0]       ecode;
        logic signed [VAL_W-1:0] evalue;
    } touch_event_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] raw_x;
        logic signed [VAL_W-1:0] raw_y;
        logic [SCR_W-1:0]        screen_x;
        logic [SCR_W-1:0]        screen_y;
    } tap_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [TYPE_W-1:0]       s_event_type = '0;
    logic [CODE_W-1:0]       s_event_code = '0;
    logic signed [VAL_W-1:0] s_event_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [VAL_W-1:0] m_raw_x;
    logic signed [VAL_W-1:0] m_raw_y;
    logic [SCR_W-1:0]        m_screen_x;
    logic [SCR_W-1:0]        m_screen_y;
    logic                    cfg_we = 1'b0;
    logic [CIDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    touch_event_t events_to_send[$];
    tap_result_t  tap_results_due[$];
    int           tap_errors = 0;

    // Predicted touch state and calibration bounds
    bit     pen_is_down = 1'b0;
    int     pressure_level = 0;
    int     last_x = 0;
    int     last_y = 0;
    bit     have_x = 1'b0;
    bit     have_y = 1'b0;
    longint acc_x = 0;
    longint acc_y = 0;
    int     n_samples = 0;
    int     x_lo = CAL_X_MIN_RST;
    int     x_hi = CAL_X_MAX_RST;
    int     y_lo = CAL_Y_MIN_RST;
    int     y_hi = CAL_Y_MAX_RST;

    touch_event_t next_ev;
    int           burst_left = 0;
    int           gap_left = 0;
    int           hold_left = 0;
    logic [9:0]   rx_tick = '0;
    int           quiet_cycles = 0;
    tap_result_t  got;
    tap_result_t  want;

    touch_tap_average_and_map u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_event_type  (s_event_type),
        .s_event_code  (s_event_code),
        .s_event_value (s_event_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_raw_x       (m_raw_x),
        .m_raw_y       (m_raw_y),
        .m_screen_x    (m_screen_x),
        .m_screen_y    (m_screen_y),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Clamp to the bounds and scale onto 0 .. size-1; collapsed or inverted bounds give 0
    function automatic logic [SCR_W-1:0] scale_axis(int v, int lo, int hi, int size);
        longint offset_scaled;
        if (hi <= lo) return '0;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        offset_scaled = longint'(v - lo) * longint'(size - 1);
        return SCR_W'(offset_scaled / longint'(hi - lo));
    endfunction

    function automatic void clear_touch_state();
        pen_is_down = 1'b0;
        pressure_level = 0;
        last_x = 0;
        last_y = 0;
        have_x = 1'b0;
        have_y = 1'b0;
        acc_x = 0;
        acc_y = 0;
        n_samples = 0;
    endfunction

    // Advance the touch state by one accepted event; queue a tap result on release
    function automatic void track_touch_event(logic [TYPE_W-1:0] et, logic [CODE_W-1:0] ec,
                                              logic signed [VAL_W-1:0] ev);
        tap_result_t r;
        int avg_x;
        int avg_y;
        case (et)
            EVT_KEY: begin
                if (ec == KEY_TOUCH) begin
                    if (ev != 0) begin
                        pen_is_down = 1'b1;
                    end else if (pen_is_down && n_samples > 0) begin
                        avg_x = int'(acc_x / longint'(n_samples));
                        avg_y = int'(acc_y / longint'(n_samples));
                        r.raw_x    = VAL_W'(avg_x);
                        r.raw_y    = VAL_W'(avg_y);
                        r.screen_x = scale_axis(avg_x, x_lo, x_hi, SCREEN_WIDTH);
                        r.screen_y = scale_axis(avg_y, y_lo, y_hi, SCREEN_HEIGHT);
                        tap_results_due.push_back(r);
                        clear_touch_state();
                    end else begin
                        pen_is_down = 1'b0;
                    end
                end
            end
            EVT_ABS: begin
                case (ec)
                    AXIS_PRESSURE: pressure_level = ev;
                    AXIS_X: begin
                        last_x = ev;
                        have_x = 1'b1;
                    end
                    AXIS_Y: begin
                        last_y = ev;
                        have_y = 1'b1;
                    end
                    default: ;
                endcase
            end
            EVT_SYNC: begin
                if (ec == SYNC_REPORT && pen_is_down && pressure_level > 0 && have_x && have_y
                        && n_samples < MAX_SAMPLES) begin
                    acc_x += last_x;
                    acc_y += last_y;
                    n_samples++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void push_event(logic [TYPE_W-1:0] et, logic [CODE_W-1:0] ec,
                                       logic signed [VAL_W-1:0] ev);
        touch_event_t e;
        e.etype  = et;
        e.ecode  = ec;
        e.evalue = ev;
        events_to_send.push_back(e);
    endfunction

    // Mostly near the calibration window, now and then anywhere in range
    function automatic logic signed [VAL_W-1:0] axis_sample(int lo, int hi);
        int a;
        int b;
        if ($urandom_range(0, 5) == 0) return VAL_W'($urandom);
        a = ((lo < hi) ? lo : hi) - 300;
        b = ((lo < hi) ? hi : lo) + 300;
        if (a < -32768) a = -32768;
        if (b > 32767) b = 32767;
        return VAL_W'(a + int'($urandom_range(0, b - a)));
    endfunction

    // One tap with random content; a few are broken or carry stray events
    function automatic void queue_random_tap();
        int reports;
        logic signed [VAL_W-1:0] pv;
        reports = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
        if ($urandom_range(0, 9) != 0)
            push_event(EVT_KEY, KEY_TOUCH, VAL_W'($urandom_range(1, 65535)));
        if ($urandom_range(0, 7) != 0)
            push_event(EVT_ABS, AXIS_PRESSURE, VAL_W'($urandom_range(1, 4095)));
        repeat (reports) begin
            if ($urandom_range(0, 4) == 0) begin
                pv = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom)
                                                 : VAL_W'($urandom_range(1, 32767));
                push_event(EVT_ABS, AXIS_PRESSURE, pv);
            end
            if ($urandom_range(0, 7) != 0) push_event(EVT_ABS, AXIS_X, axis_sample(x_lo, x_hi));
            if ($urandom_range(0, 7) != 0) push_event(EVT_ABS, AXIS_Y, axis_sample(y_lo, y_hi));
            if ($urandom_range(0, 9) == 0)
                push_event(TYPE_W'($urandom), CODE_W'($urandom_range(0, 767)), VAL_W'($urandom));
            if ($urandom_range(0, 14) == 0)
                push_event(EVT_KEY, KEY_TOUCH, VAL_W'($urandom_range(1, 65535)));
            push_event(EVT_SYNC,
                       ($urandom_range(0, 11) == 0) ? CODE_W'($urandom_range(1, 767)) : SYNC_REPORT,
                       VAL_W'($urandom));
        end
        push_event(EVT_KEY, KEY_TOUCH, '0);
    endfunction

    task automatic write_bound(input logic [CIDX_W-1:0] idx, input int val);
        logic signed [CFG_W-1:0] v16;
        v16 = CFG_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v16;
        case (idx)
            CFG_X_MIN: x_lo = v16;
            CFG_X_MAX: x_hi = v16;
            CFG_Y_MIN: y_lo = v16;
            CFG_Y_MAX: y_hi = v16;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_bounds(input int xl, input int xh, input int yl, input int yh);
        write_bound(CFG_X_MIN, xl);
        write_bound(CFG_X_MAX, xh);
        write_bound(CFG_Y_MIN, yl);
        write_bound(CFG_Y_MAX, yh);
    endtask

    // Drain the sender, collect every due tap, then let the lanes settle
    task automatic wait_idle();
        while (events_to_send.size() != 0 || s_valid || tap_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Event driver: bursts of transactions with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                track_touch_event(s_event_type, s_event_code, s_event_value);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (events_to_send.size() != 0) begin
                    next_ev = events_to_send.pop_front();
                    s_valid       <= 1'b1;
                    s_event_type  <= next_ev.etype;
                    s_event_code  <= next_ev.ecode;
                    s_event_value <= next_ev.evalue;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: a free-flowing window whenever rx_tick[9:7] is zero, random stalls elsewhere
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick[9:7] == 3'd0) begin
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor: compare each transaction with the oldest due tap
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.raw_x    = m_raw_x;
            got.raw_y    = m_raw_y;
            got.screen_x = m_screen_x;
            got.screen_y = m_screen_y;
            if (tap_results_due.size() == 0) begin
                if (tap_errors < 10)
                    $display("unexpected tap result: raw %0d,%0d screen %0d,%0d",
                             got.raw_x, got.raw_y, got.screen_x, got.screen_y);
                tap_errors++;
            end else begin
                want = tap_results_due.pop_front();
                if (got.raw_x !== want.raw_x || got.raw_y !== want.raw_y
                        || got.screen_x !== want.screen_x || got.screen_y !== want.screen_y) begin
                    if (tap_errors < 10) begin
                        $display("tap mismatch: expected raw %0d,%0d screen %0d,%0d",
                                 want.raw_x, want.raw_y, want.screen_x, want.screen_y);
                        $display("              got      raw %0d,%0d screen %0d,%0d",
                                 got.raw_x, got.raw_y, got.screen_x, got.screen_y);
                    end
                    tap_errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction or write happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: stray events, empty releases, extreme samples, pressure drop
        push_event(TYPE_W'(31), CODE_W'(767), VAL_W'(-32768));
        push_event(TYPE_W'(2), KEY_TOUCH, VAL_W'(1));
        push_event(EVT_ABS, CODE_W'(767), VAL_W'(32767));
        push_event(EVT_KEY, CODE_W'(0), VAL_W'(1));
        push_event(EVT_KEY, KEY_TOUCH, '0);
        push_event(EVT_KEY, KEY_TOUCH, VAL_W'(1));
        push_event(EVT_KEY, KEY_TOUCH, '0);
        push_event(EVT_KEY, KEY_TOUCH, VAL_W'(-1));
        push_event(EVT_KEY, KEY_TOUCH, VAL_W'(32767));
        push_event(EVT_ABS, AXIS_PRESSURE, VAL_W'(32767));
        push_event(EVT_ABS, AXIS_X, VAL_W'(-32768));
        push_event(EVT_ABS, AXIS_Y, VAL_W'(32767));
        push_event(EVT_SYNC, SYNC_REPORT, '0);
        push_event(EVT_ABS, AXIS_X, VAL_W'(-3));
        push_event(EVT_ABS, AXIS_Y, VAL_W'(-4));
        push_event(EVT_SYNC, SYNC_REPORT, '0);
        push_event(EVT_SYNC, CODE_W'(1), '0);
        push_event(EVT_ABS, AXIS_PRESSURE, '0);
        push_event(EVT_SYNC, SYNC_REPORT, '0);
        push_event(EVT_ABS, AXIS_PRESSURE, VAL_W'(5));
        push_event(EVT_SYNC, SYNC_REPORT, '0);
        push_event(EVT_KEY, KEY_TOUCH, '0);
        wait_idle();

        // Widest possible bounds
        set_bounds(-32768, 32767, -32768, 32767);
        while (events_to_send.size() < 150) queue_random_tap();
        wait_idle();

        // Equal bounds on X, inverted on Y: both screen coordinates stay zero
        set_bounds(1000, 1000, 2000, -2000);
        while (events_to_send.size() < 100) queue_random_tap();
        wait_idle();

        // One long tap that runs the sample count into saturation
        set_bounds(0, 4095, 0, 4095);
        push_event(EVT_KEY, KEY_TOUCH, VAL_W'(1));
        push_event(EVT_ABS, AXIS_PRESSURE, VAL_W'(100));
        push_event(EVT_ABS, AXIS_X, axis_sample(x_lo, x_hi));
        push_event(EVT_ABS, AXIS_Y, axis_sample(y_lo, y_hi));
        repeat (MAX_SAMPLES + 8) begin
            if ($urandom_range(0, 31) == 0) push_event(EVT_ABS, AXIS_X, axis_sample(x_lo, x_hi));
            if ($urandom_range(0, 31) == 0) push_event(EVT_ABS, AXIS_Y, axis_sample(y_lo, y_hi));
            push_event(EVT_SYNC, SYNC_REPORT, '0);
        end
        push_event(EVT_KEY, KEY_TOUCH, '0);
        wait_idle();

        // Random calibrations: arbitrary, one-step wide, and typical panels
        repeat (6) begin
            case ($urandom_range(0, 3))
                0: set_bounds(int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768);
                1: begin
                    x_lo = $urandom_range(0, 4000);
                    y_lo = $urandom_range(0, 4000);
                    set_bounds(x_lo, x_lo + 1, y_lo, y_lo + 1);
                end
                default: set_bounds($urandom_range(0, 1000), $urandom_range(2000, 4095),
                                    $urandom_range(0, 1000), $urandom_range(2000, 4095));
            endcase
            while (events_to_send.size() < 60) queue_random_tap();
            wait_idle();
        end

        tap_errors += tap_results_due.size();
        if (tap_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ttam_pkg.sv
src/ttam_div.sv
src/ttam_lane.sv
src/touch_tap_average_and_map.sv
tb/tb_top.sv
